@@ hw/rtl/gpv_pkg.sv @@
// shared constants for the gravity pull velocity block
// field widths, register indexes and register reset values; no dependencies
`default_nettype none

package gpv_pkg;

    localparam int POS_BITS_DEF = 24;
    localparam int GAIN_BITS    = 16;
    localparam int ACC_BITS     = 16;
    localparam int DIST_BITS    = 24;
    localparam int OUT_BITS     = 32;
    // gain * |acceleration| is at most 65535 * 32768, so 31 bits
    localparam int GA_BITS      = 31;
    // falloff divide works on q * 4096 and yields at most q * 16
    localparam int FALL_SHIFT   = 12;
    localparam int FALL_EXTRA   = 4;
    // sqrt(d) in q.8 is taken from d shifted up by 16
    localparam int ROOT_SHIFT   = 16;
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ACCELERATION = 2'd0,
        REG_MIN_DISTANCE = 2'd1,
        REG_MAX_DISTANCE = 2'd2,
        REG_FALLOFF_DIST = 2'd3
    } reg_index_t;

    localparam logic [ACC_BITS-1:0]  ACCELERATION_RST = 16'd256;
    localparam logic [DIST_BITS-1:0] MIN_DISTANCE_RST = 24'd0;
    localparam logic [DIST_BITS-1:0] MAX_DISTANCE_RST = 24'd0;
    localparam logic [DIST_BITS-1:0] FALLOFF_DIST_RST = 24'hFFFFFF;

endpackage

`default_nettype wire

@@ hw/rtl/gravity_pull_velocity.sv @@
// gravity_pull_velocity: one request per cycle unless an untaken result stalls the pipe;
// it has 3 front stages, POS_BITS + 2 root stages, 32 divide stages with the falloff
// root inside, 36 falloff divide stages and the output register
// the long latency is set by the bit-per-stage root and the two restoring dividers
// rst_n is asynchronous, active low: clears valid bits and loads register defaults
// depends on gpv_pkg
`default_nettype none

module gravity_pull_velocity #(
    parameter int POS_BITS = gpv_pkg::POS_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [gpv_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [gpv_pkg::DIST_BITS-1:0]     cfg_data,
    // request stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // well_x, well_y, body_x, body_y, step_gain, zero pad
    input  wire logic [((4*POS_BITS+gpv_pkg::GAIN_BITS+7)/8)*8-1:0] s_tdata,
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // speed_dx, speed_dy
    output logic [2*gpv_pkg::OUT_BITS-1:0]         m_tdata
);

    // derived widths
    localparam int DW = POS_BITS + 1;                // difference and distance
    localparam int GW = gpv_pkg::GA_BITS;            // gain * |acceleration|
    localparam int NW = DW + GW;                     // divide numerator
    localparam int SW = 2 * DW;                      // sum of squares
    localparam int RB = DW;                          // distance root bits
    localparam int QB = GW;                          // first quotient bits
    localparam int SB = (POS_BITS + 18) / 2;         // falloff root bits
    localparam int XW = 2 * SB;                      // falloff root radicand
    localparam int Q2 = QB + gpv_pkg::FALL_EXTRA;    // falloff quotient bits
    localparam int N2 = QB + gpv_pkg::FALL_SHIFT;    // falloff numerator bits
    localparam int CW = (DW > gpv_pkg::DIST_BITS) ? DW : gpv_pkg::DIST_BITS;
    localparam int OW = gpv_pkg::OUT_BITS;
    localparam int AW = gpv_pkg::ACC_BITS;

    // root stage payload
    typedef struct packed {
        logic [SW-1:0] val;
        logic [RB:0]   rem;
        logic [RB-1:0] root;
        logic [NW-1:0] nx;
        logic [NW-1:0] ny;
        logic          ngx;
        logic          ngy;
    } sq_t;

    // divide stage payload, falloff root rides along
    typedef struct packed {
        logic [DW-1:0] d;
        logic [NW-1:0] nx;
        logic [NW-1:0] ny;
        logic [DW-1:0] remx;
        logic [DW-1:0] remy;
        logic [QB-1:0] qx;
        logic [QB-1:0] qy;
        logic [XW-1:0] sv;
        logic [SB:0]   srem;
        logic [SB-1:0] sroot;
        logic          ngx;
        logic          ngy;
        logic          kill;
        logic          fall;
    } dv_t;

    // falloff divide stage payload
    typedef struct packed {
        logic [SB-1:0] s;
        logic [QB-1:0] qx;
        logic [QB-1:0] qy;
        logic [SB-1:0] rx;
        logic [SB-1:0] ry;
        logic [Q2-1:0] zx;
        logic [Q2-1:0] zy;
        logic          ngx;
        logic          ngy;
        logic          kill;
        logic          fall;
    } dz_t;

    // configuration registers
    logic [AW-1:0]                 acceleration_reg;
    logic [gpv_pkg::DIST_BITS-1:0] min_distance_reg;
    logic [gpv_pkg::DIST_BITS-1:0] max_distance_reg;
    logic [gpv_pkg::DIST_BITS-1:0] falloff_distance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acceleration_reg     <= gpv_pkg::ACCELERATION_RST;
            min_distance_reg     <= gpv_pkg::MIN_DISTANCE_RST;
            max_distance_reg     <= gpv_pkg::MAX_DISTANCE_RST;
            falloff_distance_reg <= gpv_pkg::FALLOFF_DIST_RST;
        end
        else if (cfg_wr_en)
        begin
            case (gpv_pkg::reg_index_t'(cfg_index))
                gpv_pkg::REG_ACCELERATION: acceleration_reg     <= cfg_data[AW-1:0];
                gpv_pkg::REG_MIN_DISTANCE: min_distance_reg     <= cfg_data;
                gpv_pkg::REG_MAX_DISTANCE: max_distance_reg     <= cfg_data;
                gpv_pkg::REG_FALLOFF_DIST: falloff_distance_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipe moves unless the output register holds an untaken result
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // request fields
    logic [POS_BITS-1:0]           well_x, well_y, body_x, body_y;
    logic [gpv_pkg::GAIN_BITS-1:0] step_gain;
    assign well_x    = s_tdata[POS_BITS-1:0];
    assign well_y    = s_tdata[2*POS_BITS-1:POS_BITS];
    assign body_x    = s_tdata[3*POS_BITS-1:2*POS_BITS];
    assign body_y    = s_tdata[4*POS_BITS-1:3*POS_BITS];
    assign step_gain = s_tdata[4*POS_BITS+gpv_pkg::GAIN_BITS-1:4*POS_BITS];

    // |acceleration|, 32768 fits in 16 bits unsigned
    logic [AW-1:0] acc_mag;
    assign acc_mag = acceleration_reg[AW-1] ? AW'(-acceleration_reg) : acceleration_reg;

    // stage 1: differences and gain product
    logic                 t1_v_reg;
    logic signed [DW-1:0] t1_dx_reg, t1_dy_reg;
    logic [GW-1:0]        t1_ga_reg;
    // stage 2: magnitudes
    logic                 t2_v_reg;
    logic [DW-1:0]        t2_ax_reg, t2_ay_reg;
    logic                 t2_ngx_reg, t2_ngy_reg;
    logic [GW-1:0]        t2_ga_reg;
    // stage 3: squares and numerators
    logic                 t3_v_reg;
    logic [SW-1:0]        t3_sx_reg, t3_sy_reg;
    logic [NW-1:0]        t3_nx_reg, t3_ny_reg;
    logic                 t3_ngx_reg, t3_ngy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_v_reg <= 1'b0;
            t2_v_reg <= 1'b0;
            t3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            t1_v_reg <= s_tvalid;
            t2_v_reg <= t1_v_reg;
            t3_v_reg <= t2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_dx_reg  <= $signed({well_x[POS_BITS-1], well_x})
                        - $signed({body_x[POS_BITS-1], body_x});
            t1_dy_reg  <= $signed({well_y[POS_BITS-1], well_y})
                        - $signed({body_y[POS_BITS-1], body_y});
            t1_ga_reg  <= GW'(step_gain * acc_mag);

            t2_ax_reg  <= t1_dx_reg[DW-1] ? DW'(-t1_dx_reg) : DW'(t1_dx_reg);
            t2_ay_reg  <= t1_dy_reg[DW-1] ? DW'(-t1_dy_reg) : DW'(t1_dy_reg);
            t2_ngx_reg <= t1_dx_reg[DW-1];
            t2_ngy_reg <= t1_dy_reg[DW-1];
            t2_ga_reg  <= t1_ga_reg;

            t3_sx_reg  <= SW'(t2_ax_reg * t2_ax_reg);
            t3_sy_reg  <= SW'(t2_ay_reg * t2_ay_reg);
            t3_nx_reg  <= NW'(t2_ax_reg * t2_ga_reg);
            t3_ny_reg  <= NW'(t2_ay_reg * t2_ga_reg);
            t3_ngx_reg <= t2_ngx_reg;
            t3_ngy_reg <= t2_ngy_reg;
        end
    end

    // distance root, two radicand bits per stage
    sq_t        sq_reg  [RB+1];
    sq_t        sq_next [RB+1];
    logic [RB:0] sq_v_reg;

    always_comb
    begin
        logic [RB+2:0] tmp;
        logic [RB+2:0] trial;
        sq_next[0].val  = t3_sx_reg + t3_sy_reg;
        sq_next[0].rem  = '0;
        sq_next[0].root = '0;
        sq_next[0].nx   = t3_nx_reg;
        sq_next[0].ny   = t3_ny_reg;
        sq_next[0].ngx  = t3_ngx_reg;
        sq_next[0].ngy  = t3_ngy_reg;
        for (int i = 0; i < RB; i++)
        begin
            sq_next[i+1] = sq_reg[i];
            tmp   = {sq_reg[i].rem, sq_reg[i].val[2*(RB-1-i)+1], sq_reg[i].val[2*(RB-1-i)]};
            trial = (RB+3)'({sq_reg[i].root, 2'b01});
            if (tmp >= trial)
            begin
                sq_next[i+1].rem  = (RB+1)'(tmp - trial);
                sq_next[i+1].root = {sq_reg[i].root[RB-2:0], 1'b1};
            end
            else
            begin
                sq_next[i+1].rem  = tmp[RB:0];
                sq_next[i+1].root = {sq_reg[i].root[RB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg <= '0;
        else if (en)
            sq_v_reg <= {sq_v_reg[RB-1:0], t3_v_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sq_reg <= sq_next;
    end

    // band checks, then component divide by d and falloff root of d
    dv_t        dv_reg  [QB+1];
    dv_t        dv_next [QB+1];
    logic [QB:0] dv_v_reg;
    logic [DW-1:0] dist_root;
    assign dist_root = sq_reg[RB].root;

    always_comb
    begin
        logic [DW:0]   tx;
        logic [DW:0]   ty;
        logic [SB+2:0] st;
        logic [SB+2:0] strial;
        dv_next[0].d     = dist_root;
        dv_next[0].nx    = sq_reg[RB].nx;
        dv_next[0].ny    = sq_reg[RB].ny;
        dv_next[0].remx  = sq_reg[RB].nx[NW-1:QB];
        dv_next[0].remy  = sq_reg[RB].ny[NW-1:QB];
        dv_next[0].qx    = '0;
        dv_next[0].qy    = '0;
        dv_next[0].sv    = XW'({dist_root, {gpv_pkg::ROOT_SHIFT{1'b0}}});
        dv_next[0].srem  = '0;
        dv_next[0].sroot = '0;
        dv_next[0].ngx   = sq_reg[RB].ngx;
        dv_next[0].ngy   = sq_reg[RB].ngy;
        // zero distance, too close, or too far with the limit enabled
        dv_next[0].kill  = (dist_root == '0)
                         || (CW'(dist_root) < CW'(min_distance_reg))
                         || ((max_distance_reg != '0)
                             && (CW'(dist_root) >= CW'(max_distance_reg)));
        dv_next[0].fall  = CW'(dist_root) >= CW'(falloff_distance_reg);
        for (int i = 0; i < QB; i++)
        begin
            dv_next[i+1] = dv_reg[i];
            tx = {dv_reg[i].remx, dv_reg[i].nx[QB-1-i]};
            ty = {dv_reg[i].remy, dv_reg[i].ny[QB-1-i]};
            if (tx >= {1'b0, dv_reg[i].d})
            begin
                dv_next[i+1].remx = DW'(tx - {1'b0, dv_reg[i].d});
                dv_next[i+1].qx   = {dv_reg[i].qx[QB-2:0], 1'b1};
            end
            else
            begin
                dv_next[i+1].remx = tx[DW-1:0];
                dv_next[i+1].qx   = {dv_reg[i].qx[QB-2:0], 1'b0};
            end
            if (ty >= {1'b0, dv_reg[i].d})
            begin
                dv_next[i+1].remy = DW'(ty - {1'b0, dv_reg[i].d});
                dv_next[i+1].qy   = {dv_reg[i].qy[QB-2:0], 1'b1};
            end
            else
            begin
                dv_next[i+1].remy = ty[DW-1:0];
                dv_next[i+1].qy   = {dv_reg[i].qy[QB-2:0], 1'b0};
            end
            if (i < SB)
            begin
                st     = {dv_reg[i].srem, dv_reg[i].sv[2*(SB-1-i)+1], dv_reg[i].sv[2*(SB-1-i)]};
                strial = (SB+3)'({dv_reg[i].sroot, 2'b01});
                if (st >= strial)
                begin
                    dv_next[i+1].srem  = (SB+1)'(st - strial);
                    dv_next[i+1].sroot = {dv_reg[i].sroot[SB-2:0], 1'b1};
                end
                else
                begin
                    dv_next[i+1].srem  = st[SB:0];
                    dv_next[i+1].sroot = {dv_reg[i].sroot[SB-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg <= '0;
        else if (en)
            dv_v_reg <= {dv_v_reg[QB-1:0], sq_v_reg[RB]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dv_reg <= dv_next;
    end

    // falloff divide: q * 4096 / sqrt(d in q.8)
    dz_t        dz_reg  [Q2+1];
    dz_t        dz_next [Q2+1];
    logic [Q2:0] dz_v_reg;

    always_comb
    begin
        logic [N2-1:0] numx;
        logic [N2-1:0] numy;
        logic [SB:0]   tx;
        logic [SB:0]   ty;
        numx = '0;
        numy = '0;
        dz_next[0].s    = dv_reg[QB].sroot;
        dz_next[0].qx   = dv_reg[QB].qx;
        dz_next[0].qy   = dv_reg[QB].qy;
        dz_next[0].rx   = SB'(dv_reg[QB].qx[QB-1:Q2-gpv_pkg::FALL_SHIFT]);
        dz_next[0].ry   = SB'(dv_reg[QB].qy[QB-1:Q2-gpv_pkg::FALL_SHIFT]);
        dz_next[0].zx   = '0;
        dz_next[0].zy   = '0;
        dz_next[0].ngx  = dv_reg[QB].ngx;
        dz_next[0].ngy  = dv_reg[QB].ngy;
        dz_next[0].kill = dv_reg[QB].kill;
        dz_next[0].fall = dv_reg[QB].fall;
        for (int i = 0; i < Q2; i++)
        begin
            dz_next[i+1] = dz_reg[i];
            numx = {dz_reg[i].qx, {gpv_pkg::FALL_SHIFT{1'b0}}};
            numy = {dz_reg[i].qy, {gpv_pkg::FALL_SHIFT{1'b0}}};
            tx = {dz_reg[i].rx, numx[Q2-1-i]};
            ty = {dz_reg[i].ry, numy[Q2-1-i]};
            if (tx >= {1'b0, dz_reg[i].s})
            begin
                dz_next[i+1].rx = SB'(tx - {1'b0, dz_reg[i].s});
                dz_next[i+1].zx = {dz_reg[i].zx[Q2-2:0], 1'b1};
            end
            else
            begin
                dz_next[i+1].rx = tx[SB-1:0];
                dz_next[i+1].zx = {dz_reg[i].zx[Q2-2:0], 1'b0};
            end
            if (ty >= {1'b0, dz_reg[i].s})
            begin
                dz_next[i+1].ry = SB'(ty - {1'b0, dz_reg[i].s});
                dz_next[i+1].zy = {dz_reg[i].zy[Q2-2:0], 1'b1};
            end
            else
            begin
                dz_next[i+1].ry = ty[SB-1:0];
                dz_next[i+1].zy = {dz_reg[i].zy[Q2-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dz_v_reg <= '0;
        else if (en)
            dz_v_reg <= {dz_v_reg[Q2-1:0], dv_v_reg[QB]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dz_reg <= dz_next;
    end

    // clamp the magnitude, then apply the sign
    function automatic logic [OW-1:0] saturate(input logic [Q2-1:0] mag, input logic neg);
        logic [Q2-1:0] lim;
        logic [Q2-1:0] m;
        lim = neg ? Q2'(33'h080000000) : Q2'(33'h07FFFFFFF);
        m   = (mag > lim) ? lim : mag;
        return neg ? OW'(-m) : OW'(m);
    endfunction

    logic [Q2-1:0] mag_x, mag_y;
    logic          neg_x, neg_y;
    logic [OW-1:0] speed_dx_next, speed_dy_next;

    always_comb
    begin
        mag_x = dz_reg[Q2].fall ? dz_reg[Q2].zx : Q2'(dz_reg[Q2].qx);
        mag_y = dz_reg[Q2].fall ? dz_reg[Q2].zy : Q2'(dz_reg[Q2].qy);
        neg_x = dz_reg[Q2].ngx ^ acceleration_reg[AW-1];
        neg_y = dz_reg[Q2].ngy ^ acceleration_reg[AW-1];
        if (dz_reg[Q2].kill)
        begin
            speed_dx_next = '0;
            speed_dy_next = '0;
        end
        else
        begin
            speed_dx_next = saturate(mag_x, neg_x);
            speed_dy_next = saturate(mag_y, neg_y);
        end
    end

    // output register
    logic          out_v_reg;
    logic [OW-1:0] speed_dx_reg, speed_dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= dz_v_reg[Q2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            speed_dx_reg <= speed_dx_next;
            speed_dy_reg <= speed_dy_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {speed_dy_reg, speed_dx_reg};

    // a live item at the end of the falloff divide always lands in the output
    a_last_stage_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (en && dz_v_reg[Q2]) |=> m_tvalid)
        else $error("result lost between last divide stage and output");

    // numerator never reaches d times 2^31, so the remainder stays under d
    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_v_reg[QB] && !dv_reg[QB].kill) |->
            ((dv_reg[QB].remx < dv_reg[QB].d) && (dv_reg[QB].remy < dv_reg[QB].d)))
        else $error("component divide remainder out of range");

    // root of a nonzero distance in q.8 is at least 256, above the falloff start value
    a_fall_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (dz_v_reg[Q2] && !dz_reg[Q2].kill) |->
            ((dz_reg[Q2].rx < dz_reg[Q2].s) && (dz_reg[Q2].ry < dz_reg[Q2].s)))
        else $error("falloff divide remainder out of range");

endmodule

`default_nettype wire
